FILE: hw/rtl/battery_pack_mode_controller_macros.svh
// assertion macros for the battery pack mode controller checker
`ifndef BATTERY_PACK_MODE_CONTROLLER_MACROS_SVH
`define BATTERY_PACK_MODE_CONTROLLER_MACROS_SVH

// same-cycle implication, disabled during reset
`define BPMC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BPMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/bpmc_pkg.sv
// types, codes and helpers shared by the battery pack mode controller
package bpmc_pkg;

    localparam int ADC_W      = 10;
    localparam int IDLE_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int MAX_CELLS  = 6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UNDERVOLT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP     = 2'd2;

    localparam logic [ADC_W-1:0]  UNDERVOLT_RST = 10'd573;
    localparam logic [ADC_W-1:0]  FULL_RST      = 10'd859;
    localparam logic [IDLE_W-1:0] SLEEP_RST     = 16'd1000;

    // pack mode codes as reported on the output
    localparam logic [2:0] PACK_IDLE = 3'd0;
    localparam logic [2:0] PACK_WAIT = 3'd1;
    localparam logic [2:0] PACK_ON   = 3'd2;
    localparam logic [2:0] PACK_CHG  = 3'd3;
    localparam logic [2:0] PACK_UV   = 3'd4;
    localparam logic [2:0] PACK_FULL = 3'd5;

    typedef enum logic [5:0] {
        MODE_IDLE = 6'b000001,
        MODE_WAIT = 6'b000010,
        MODE_ON   = 6'b000100,
        MODE_CHG  = 6'b001000,
        MODE_UV   = 6'b010000,
        MODE_FULL = 6'b100000
    } mode_t;

    typedef enum logic [1:0] {
        FET_OFF     = 2'd0,
        FET_DIS     = 2'd1,
        FET_CHG     = 2'd2,
        FET_STANDBY = 2'd3
    } fet_cmd_t;

    typedef struct packed {
        logic             data_valid;
        logic [ADC_W-1:0] cell_v0;
        logic [ADC_W-1:0] cell_v1;
        logic [ADC_W-1:0] cell_v2;
        logic [ADC_W-1:0] cell_v3;
        logic [ADC_W-1:0] cell_v4;
        logic [ADC_W-1:0] cell_v5;
        logic             button_pressed;
        logic             charger_present;
        logic             ctrl_idle;
    } tick_t;

    typedef struct packed {
        logic [2:0] pack_mode;
        logic       fet_write;
        logic [1:0] fet_cmd;
        logic       red_on;
        logic       blue_on;
        logic       green_on;
    } report_t;

    typedef struct packed {
        mode_t             mode;
        logic [IDLE_W-1:0] idle_count;
        logic              red_led;
        logic              blue_led;
        logic              green_led;
        fet_cmd_t          last_cmd;
    } pack_state_t;

    typedef struct packed {
        logic [ADC_W-1:0]  undervolt;
        logic [ADC_W-1:0]  full;
        logic [IDLE_W-1:0] sleep_ticks;
    } thresh_t;

    function automatic logic [2:0] mode_code(input mode_t mode);
        logic [2:0] code;
        unique case (mode)
            MODE_IDLE: code = PACK_IDLE;
            MODE_WAIT: code = PACK_WAIT;
            MODE_ON:   code = PACK_ON;
            MODE_CHG:  code = PACK_CHG;
            MODE_UV:   code = PACK_UV;
            MODE_FULL: code = PACK_FULL;
            default:   code = PACK_IDLE;
        endcase
        return code;
    endfunction

endpackage

FILE: hw/rtl/bpmc_stream_if.sv
// valid/ready channel carrying one word of a given payload type
interface bpmc_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/battery_pack_mode_controller.sv
// battery pack mode controller: one tick word in, one status word out
// status path: an accepted tick loads the input register, then the status register once it is free
// throughput: one tick per cycle while status words are taken; the mode update is combinational logic between them
// the status register frees the input side while a finished word waits to be taken
// reset: mode idle, idle count zero, leds off, last fet command all off,
// thresholds 573 and 859, sleep limit 1000 ticks
module battery_pack_mode_controller
    import bpmc_pkg::*;
#(
    parameter int NUM_CELLS = 6,
    parameter int ADC_BITS  = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    bpmc_stream_if.sink           tick,
    bpmc_stream_if.source         report
);

    thresh_t     thresh_reg;
    tick_t       tick_reg;
    logic        tick_valid_reg;
    pack_state_t state_reg;
    pack_state_t state_next;
    report_t     report_reg;
    report_t     report_next;
    logic        report_valid_reg;
    logic        fet_write;
    logic        accept;
    logic        advance;

    assign advance    = tick_valid_reg && (!report_valid_reg || report.ready);
    assign tick.ready = !tick_valid_reg || advance;
    assign accept     = tick.valid && tick.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg.undervolt   <= UNDERVOLT_RST;
            thresh_reg.full        <= FULL_RST;
            thresh_reg.sleep_ticks <= SLEEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_UNDERVOLT: thresh_reg.undervolt   <= cfg_data[ADC_W-1:0];
                CFG_FULL:      thresh_reg.full        <= cfg_data[ADC_W-1:0];
                CFG_SLEEP:     thresh_reg.sleep_ticks <= cfg_data[IDLE_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            tick_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            tick_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tick_reg <= tick.payload;
        end
    end

    bpmc_step #(
        .NUM_CELLS (NUM_CELLS),
        .ADC_BITS  (ADC_BITS)
    ) u_step (
        .tick_word  (tick_reg),
        .thresh     (thresh_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .fet_write  (fet_write)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode       <= MODE_IDLE;
            state_reg.idle_count <= '0;
            state_reg.red_led    <= 1'b0;
            state_reg.blue_led   <= 1'b0;
            state_reg.green_led  <= 1'b0;
            state_reg.last_cmd   <= FET_OFF;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        report_next.pack_mode = mode_code(state_next.mode);
        report_next.fet_write = fet_write;
        report_next.fet_cmd   = state_next.last_cmd;
        report_next.red_on    = state_next.red_led;
        report_next.blue_on   = state_next.blue_led;
        report_next.green_on  = state_next.green_led;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            report_valid_reg <= 1'b1;
        end
        else if (report.ready)
        begin
            report_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            report_reg <= report_next;
        end
    end

    assign report.valid   = report_valid_reg;
    assign report.payload = report_reg;

endmodule

FILE: hw/rtl/bpmc_step.sv
// next-state logic for one tick: cell checks, button, charger, idle and sleep
module bpmc_step
    import bpmc_pkg::*;
#(
    parameter int NUM_CELLS = 6,
    parameter int ADC_BITS  = 10
) (
    input  tick_t       tick_word,
    input  thresh_t     thresh,
    input  pack_state_t state_cur,
    output pack_state_t state_next,
    output logic        fet_write
);

    localparam int CMP_BITS = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;

    logic [ADC_W-1:0] cell_v [MAX_CELLS];
    logic             low_hit;
    logic             high_hit;
    pack_state_t      work;
    logic             wrote;

    assign cell_v[0] = tick_word.cell_v0;
    assign cell_v[1] = tick_word.cell_v1;
    assign cell_v[2] = tick_word.cell_v2;
    assign cell_v[3] = tick_word.cell_v3;
    assign cell_v[4] = tick_word.cell_v4;
    assign cell_v[5] = tick_word.cell_v5;

    // a cell under the low threshold is never tested against the high one
    always_comb
    begin
        low_hit  = 1'b0;
        high_hit = 1'b0;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            if (cell_v[i][CMP_BITS-1:0] < thresh.undervolt[CMP_BITS-1:0])
            begin
                low_hit = 1'b1;
            end
            else if (cell_v[i][CMP_BITS-1:0] > thresh.full[CMP_BITS-1:0])
            begin
                high_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        work  = state_cur;
        wrote = 1'b0;
        if (tick_word.data_valid)
        begin
            // cell limits, no idle count clear here
            if (work.mode == MODE_ON && low_hit)
            begin
                work.blue_led = 1'b0;
                work.red_led  = 1'b1;
                work.mode     = MODE_UV;
                work.last_cmd = FET_OFF;
                wrote         = 1'b1;
            end
            else if (work.mode == MODE_CHG && high_hit)
            begin
                work.green_led = 1'b1;
                work.blue_led  = 1'b0;
                work.mode      = MODE_FULL;
                work.last_cmd  = FET_OFF;
                wrote          = 1'b1;
            end

            if (tick_word.button_pressed)
            begin
                if (work.mode == MODE_IDLE)
                begin
                    work.blue_led   = 1'b1;
                    work.last_cmd   = FET_DIS;
                    work.mode       = MODE_ON;
                    work.idle_count = '0;
                    wrote           = 1'b1;
                end
            end
            else if (work.mode == MODE_ON)
            begin
                work.blue_led   = 1'b0;
                work.last_cmd   = FET_OFF;
                work.mode       = MODE_IDLE;
                work.idle_count = '0;
                wrote           = 1'b1;
            end

            if (tick_word.charger_present)
            begin
                if (work.mode == MODE_IDLE || work.mode == MODE_UV
                    || work.mode == MODE_WAIT)
                begin
                    work.blue_led   = 1'b1;
                    work.red_led    = 1'b0;
                    work.last_cmd   = FET_CHG;
                    work.mode       = MODE_CHG;
                    work.idle_count = '0;
                    wrote           = 1'b1;
                end
            end
            else if (work.mode == MODE_CHG || work.mode == MODE_FULL)
            begin
                work.blue_led   = 1'b0;
                work.green_led  = 1'b0;
                work.last_cmd   = FET_OFF;
                work.mode       = MODE_WAIT;
                work.idle_count = '0;
                wrote           = 1'b1;
            end

            if (work.mode == MODE_WAIT)
            begin
                work.idle_count = '0;
                if (tick_word.ctrl_idle)
                begin
                    work.mode = MODE_IDLE;
                end
            end

            if (work.idle_count != '1)
            begin
                work.idle_count = work.idle_count + 1'b1;
            end

            if (work.idle_count > thresh.sleep_ticks
                && (work.mode == MODE_IDLE || work.mode == MODE_UV))
            begin
                work.red_led   = 1'b0;
                work.blue_led  = 1'b0;
                work.green_led = 1'b0;
                work.last_cmd  = FET_STANDBY;
                wrote          = 1'b1;
            end
        end
    end

    assign state_next = work;
    assign fet_write  = wrote;

endmodule

FILE: hw/rtl/bpmc_checker.sv
// port-level checks on the status channel of the battery pack mode controller
`include "battery_pack_mode_controller_macros.svh"

module bpmc_checker
    import bpmc_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    report_valid,
    input logic    report_ready,
    input report_t report_payload
);

    `BPMC_ASSERT_NEXT(a_stall_hold, clk, rst_n, report_valid && !report_ready, report_valid && $stable(report_payload), "status word changed while stalled")
    `BPMC_ASSERT_IMPLY(a_sleep_dark, clk, rst_n, report_valid && report_payload.fet_write && report_payload.fet_cmd == FET_STANDBY, !report_payload.red_on && !report_payload.blue_on && !report_payload.green_on, "sleep issued with an led lit")
    `BPMC_ASSERT_IMPLY(a_active_blue, clk, rst_n, report_valid && (report_payload.pack_mode == PACK_ON || report_payload.pack_mode == PACK_CHG), report_payload.blue_on, "on or charging without blue led")
    `BPMC_ASSERT_IMPLY(a_full_green, clk, rst_n, report_valid && report_payload.pack_mode == PACK_FULL, report_payload.green_on && !report_payload.blue_on, "charged without green led")

endmodule

bind battery_pack_mode_controller bpmc_checker u_bpmc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .report_valid   (report.valid),
    .report_ready   (report.ready),
    .report_payload (report.payload)
);
